FILE: hw/rtl/sps_pkg.sv
// Shared types and constants for the seven-point stencil matvec block.
// Item payload structs, register indexes, op codes and MAC control.
// No dependencies.
package sps_pkg;

   localparam int COORD_W   = 4;
   localparam int SIZE_W    = 5;
   localparam int FIELD_W   = 32;
   localparam int OUT_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

   typedef struct packed {
      logic                      op;
      logic [COORD_W-1:0]        cell_x;
      logic [COORD_W-1:0]        cell_y;
      logic [COORD_W-1:0]        cell_z;
      logic signed [FIELD_W-1:0] diag_coef;
      logic signed [FIELD_W-1:0] xpos_coef;
      logic signed [FIELD_W-1:0] ypos_coef;
      logic signed [FIELD_W-1:0] zpos_coef;
      logic signed [FIELD_W-1:0] vec_value;
      logic                      is_fluid;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] product;
      logic                    active;
   } rsp_type;

   typedef struct packed {
      logic clear;    // zero the accumulator
      logic mul_en;   // operands valid this cycle
   } mac_ctl_type;

endpackage

FILE: hw/rtl/sps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module sps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sps_mac.sv
// Shared multiply-accumulate unit: one signed multiply per cycle, floor shift,
// exact accumulate and saturation to the 48-bit result. Uses sps_pkg.
module sps_mac import sps_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctl_type                   ctl,
   input  logic signed [VALUE_WIDTH-1:0] coef,
   input  logic signed [VALUE_WIDTH-1:0] vec,
   output logic signed [OUT_W-1:0]       sum
);

   localparam int PROD_W = 2 * VALUE_WIDTH;
   // seven floored terms, each fits PROD_W - FRAC_BITS bits
   localparam int ACC_W  = PROD_W - FRAC_BITS + 3;
   localparam int SUM_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic signed [SUM_W-1:0]  term;
   logic [SUM_W-OUT_W:0]     acc_top;

   always_comb begin
      prod_in = ctl.mul_en ? coef * vec : prod_ff;
      term    = SUM_W'(prod_ff >>> FRAC_BITS);
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + term;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.mul_en;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // saturate when the result sign and the bits above it disagree
   always_comb begin
      acc_top = acc_ff[SUM_W-1:OUT_W-1];
      if ((&acc_top) || !(|acc_top)) begin
         sum = acc_ff[OUT_W-1:0];
      end else if (acc_ff[SUM_W-1]) begin
         sum = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         sum = {1'b0, {(OUT_W-1){1'b1}}};
      end
   end

endmodule

FILE: hw/rtl/seven_point_stencil_matvec.sv
// Seven-point Poisson stencil matrix-vector product over a 3D cell grid.
//
// Channels: req_* carries items (write a cell or compute at a cell), rsp_*
// carries one result per compute item, csr_* writes size_x/size_y/size_z
// (indexes 0..2, other indexes ignored). Both channels are valid/stall;
// an item moves when valid is high and stall is low.
// Cell rows live in one RAM of GRID_MAX^3 words {fluid, vec, zpos, ypos,
// xpos, diag}. A compute walks the centre and six neighbours through the
// single read port and one shared multiply-accumulate unit.
// Timing: a write is applied to the RAM in the cycle it is accepted. An
// interior compute makes seven RAM reads, then the multiply and accumulate
// stages, before its result is offered; any other compute goes straight to it.
// One item is in work at a time; req_stall is high while busy. Throughput:
// a write every cycle while idle; after a compute, the next item once its result is offered.
// The result sits in an output register: a new item is accepted while a
// result waits, and a finished compute holds while that waiting result is stalled.
// Reset: sizes return to 16 and the RAM is swept row by row to clear the
// fluid flags, with req_stall high; csr writes are taken during the sweep.
// Dependencies: sps_pkg, sps_ram, sps_mac.
module seven_point_stencil_matvec import sps_pkg::*; #(
   parameter int GRID_MAX    = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_wdata
);

   localparam int VW        = VALUE_WIDTH;
   localparam int DEPTH     = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int AW        = $clog2(DEPTH);
   localparam int WORD_W    = 5 * VW + 1;
   localparam int DIAG_LO   = 0;
   localparam int XPOS_LO   = VW;
   localparam int YPOS_LO   = 2 * VW;
   localparam int ZPOS_LO   = 3 * VW;
   localparam int VEC_LO    = 4 * VW;
   localparam int FLUID_BIT = 5 * VW;
   localparam int GW        = $clog2(GRID_MAX + 1);
   localparam int CMP_W     = ((GW > SIZE_W) ? GW : SIZE_W) + 1;
   localparam int STEP_W    = 4;

   localparam logic [STEP_W-1:0] STEP_C    = 4'd0;
   localparam logic [STEP_W-1:0] STEP_XP   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_YP   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ZP   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_XM   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_YM   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_ZM   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DONE = 4'd8;

   localparam logic [AW-1:0] OFS_X    = AW'(1);
   localparam logic [AW-1:0] OFS_Y    = AW'(GRID_MAX);
   localparam logic [AW-1:0] OFS_Z    = AW'(GRID_MAX * GRID_MAX);
   localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [VW-1:0] xpos;
      logic [VW-1:0] ypos;
      logic [VW-1:0] zpos;
      logic          fluid;
   } center_type;

   function automatic logic interior(input logic [COORD_W-1:0] c,
                                     input logic [SIZE_W-1:0]  s);
      logic [CMP_W-1:0] lim;
      lim = (CMP_W'(s) > CMP_W'(GRID_MAX)) ? CMP_W'(GRID_MAX) : CMP_W'(s);
      return (c != '0) && ((CMP_W'(c) + CMP_W'(1)) < lim);
   endfunction

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] rd_step_ff, rd_step_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [AW-1:0]     center_addr_ff, center_addr_in;
   logic              interior_ff, interior_in;
   center_type        center_ff, center_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;

   logic              accept;
   logic              rsp_free;
   logic              req_inside;
   logic              req_interior;
   logic [AW-1:0]     req_addr;
   logic              act;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   mac_ctl_type           mac_ctl;
   logic signed [VW-1:0]  mac_coef;
   logic signed [VW-1:0]  mac_vec;
   logic signed [OUT_W-1:0] mac_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata;
            CSR_SIZE_Y: size_y_ff <= csr_wdata;
            CSR_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_inside = (CMP_W'(req_data.cell_x) < CMP_W'(GRID_MAX))
                    && (CMP_W'(req_data.cell_y) < CMP_W'(GRID_MAX))
                    && (CMP_W'(req_data.cell_z) < CMP_W'(GRID_MAX));
   assign req_interior = interior(req_data.cell_x, size_x_ff)
                      && interior(req_data.cell_y, size_y_ff)
                      && interior(req_data.cell_z, size_z_ff);
   assign req_addr = AW'(req_data.cell_x)
                   + OFS_Y * AW'(req_data.cell_y)
                   + OFS_Z * AW'(req_data.cell_z);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign act       = interior_ff && center_ff.fluid;

   // neighbour walk: centre, +x, +y, +z, -x, -y, -z
   always_comb begin
      unique case (step_ff)
         STEP_C:  rd_addr = center_addr_ff;
         STEP_XP: rd_addr = center_addr_ff + OFS_X;
         STEP_YP: rd_addr = center_addr_ff + OFS_Y;
         STEP_ZP: rd_addr = center_addr_ff + OFS_Z;
         STEP_XM: rd_addr = center_addr_ff - OFS_X;
         STEP_YM: rd_addr = center_addr_ff - OFS_Y;
         STEP_ZM: rd_addr = center_addr_ff - OFS_Z;
         default: rd_addr = center_addr_ff;
      endcase
   end

   // +dir terms use the centre's coefficient, -dir terms the neighbour's own
   always_comb begin
      mac_vec = rd_data[VEC_LO +: VW];
      unique case (rd_step_ff)
         STEP_C:  mac_coef = rd_data[DIAG_LO +: VW];
         STEP_XP: mac_coef = center_ff.xpos;
         STEP_YP: mac_coef = center_ff.ypos;
         STEP_ZP: mac_coef = center_ff.zpos;
         STEP_XM: mac_coef = rd_data[XPOS_LO +: VW];
         STEP_YM: mac_coef = rd_data[YPOS_LO +: VW];
         STEP_ZM: mac_coef = rd_data[ZPOS_LO +: VW];
         default: mac_coef = rd_data[DIAG_LO +: VW];
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      rd_step_in     = step_ff;
      rd_vld_in      = 1'b0;
      clr_addr_in    = clr_addr_ff;
      center_addr_in = center_addr_ff;
      interior_in    = interior_ff;
      center_in      = center_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      wr_en   = 1'b0;
      wr_addr = req_addr;
      wr_data = {req_data.is_fluid,
                 req_data.vec_value[VW-1:0],
                 req_data.zpos_coef[VW-1:0],
                 req_data.ypos_coef[VW-1:0],
                 req_data.xpos_coef[VW-1:0],
                 req_data.diag_coef[VW-1:0]};
      rd_en   = 1'b0;

      mac_ctl.clear  = 1'b0;
      mac_ctl.mul_en = rd_vld_ff;

      if (rd_vld_ff && (rd_step_ff == STEP_C)) begin
         center_in.xpos  = rd_data[XPOS_LO +: VW];
         center_in.ypos  = rd_data[YPOS_LO +: VW];
         center_in.zpos  = rd_data[ZPOS_LO +: VW];
         center_in.fluid = rd_data[FLUID_BIT];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_WRITE) begin
                  wr_en = req_inside;
               end else begin
                  center_addr_in = req_addr;
                  interior_in    = req_interior;
                  step_in        = STEP_C;
                  mac_ctl.clear  = 1'b1;
                  state_in       = req_interior ? ST_READ : ST_DONE;
               end
            end
         end
         ST_READ: begin
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_ZM) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait out the read, multiply and accumulate stages
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_DONE) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.active  = act;
               rsp_data_in.product = act ? mac_sum : '0;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_C;
         rd_vld_ff    <= 1'b0;
         clr_addr_ff  <= '0;
         interior_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         rd_vld_ff      <= rd_vld_in;
         clr_addr_ff    <= clr_addr_in;
         interior_ff    <= interior_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_step_ff     <= rd_step_in;
         center_addr_ff <= center_addr_in;
         center_ff      <= center_in;
         rsp_data_ff    <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sps_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sps_mac #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coef  (mac_coef),
      .vec   (mac_vec),
      .sum   (mac_sum)
   );

endmodule

FILE: hw/rtl/sps_checker.sv
// Port-level checks for seven_point_stencil_matvec, bound to the top level.
// Uses sps_pkg for the payload types and op codes.
module sps_checker import sps_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // inactive cells always report zero
   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.active |-> rsp_data.product == '0)
      else $error("inactive cell with nonzero product");

   // a write item never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == OP_WRITE) && !rsp_valid
      |=> !rsp_valid)
      else $error("write item produced a result");

   // a compute item keeps the block busy in the next cycle
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.op == OP_COMPUTE) |=> req_stall)
      else $error("input taken during compute");

   // after reset: clearing sweep, nothing offered
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not quiet after reset");

endmodule

bind seven_point_stencil_matvec sps_checker u_sps_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for seven_point_stencil_matvec: directed table, then random phases.
// Predicts compute results from its own copy of the cell grid and sizes; typed table rows carry their own.
// Depends on sps_pkg and seven_point_stencil_matvec.
module testbench;
   import sps_pkg::*;

   localparam int GRID        = 16;
   localparam int GRID_CELLS  = GRID * GRID * GRID;
   localparam int FRAC        = 16;
   localparam int DRAIN       = 16;
   localparam int LIMIT       = 20000;
   localparam int PHASE_ITEMS = 180;
   localparam int PHASES      = 6;
   localparam longint SAT_HI  = 64'sd140737488355327;
   localparam longint SAT_LO  = -SAT_HI - 64'sd1;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   // grid copy
   logic signed [FIELD_W-1:0] diag_m [GRID_CELLS];
   logic signed [FIELD_W-1:0] xpos_m [GRID_CELLS];
   logic signed [FIELD_W-1:0] ypos_m [GRID_CELLS];
   logic signed [FIELD_W-1:0] zpos_m [GRID_CELLS];
   logic signed [FIELD_W-1:0] vec_m  [GRID_CELLS];
   bit                        fluid_m   [GRID_CELLS];
   bit                        written_m [GRID_CELLS];
   logic [SIZE_W-1:0] size_x_q = SIZE_RESET;
   logic [SIZE_W-1:0] size_y_q = SIZE_RESET;
   logic [SIZE_W-1:0] size_z_q = SIZE_RESET;

   rsp_type      pending_rsp [$];
   stim_row_type stim_table  [$];
   rsp_type      want_rsp;
   int           bad_count  = 0;
   int           quiet_cycles = 0;
   int           req_idle_pct = 0;
   int           rsp_idle_pct = 0;

   logic [SIZE_W-1:0] phase_sx [PHASES] = '{5'd16, 5'd6, 5'd3, 5'd31, 5'd1, 5'd4};
   logic [SIZE_W-1:0] phase_sy [PHASES] = '{5'd16, 5'd5, 5'd3, 5'd17, 5'd2, 5'd16};
   logic [SIZE_W-1:0] phase_sz [PHASES] = '{5'd16, 5'd7, 5'd3, 5'd16, 5'd16, 5'd9};

   seven_point_stencil_matvec dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [11:0] cell_index(input req_type it);
      return {it.cell_z, it.cell_y, it.cell_x};
   endfunction

   // sizes above the grid act as the grid
   function automatic bit inner(input logic [COORD_W-1:0] c, input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] lim;
      lim = (s > GRID) ? 5'(GRID) : s;
      return (c >= 1) && (c + 1 < lim);
   endfunction

   function automatic bit live_cell(input req_type it);
      return inner(it.cell_x, size_x_q) && inner(it.cell_y, size_y_q)
         && inner(it.cell_z, size_z_q) && fluid_m[cell_index(it)];
   endfunction

   // 0 centre, 1..3 positive neighbours, 4..6 negative neighbours
   function automatic req_type hood_cell(input req_type it, input int k);
      req_type r;
      r = it;
      case (k)
         1: r.cell_x = it.cell_x + 4'd1;
         2: r.cell_y = it.cell_y + 4'd1;
         3: r.cell_z = it.cell_z + 4'd1;
         4: r.cell_x = it.cell_x - 4'd1;
         5: r.cell_y = it.cell_y - 4'd1;
         6: r.cell_z = it.cell_z - 4'd1;
         default: ;
      endcase
      return r;
   endfunction

   function automatic longint mul_floor(input logic signed [FIELD_W-1:0] a,
                                        input logic signed [FIELD_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC;
   endfunction

   // updates the grid copy; returns 1 when the item yields a result
   function automatic bit predict_item(input req_type it, output rsp_type r);
      logic [11:0] c, xp, yp, zp, xm, ym, zm;
      longint      acc;
      r = '0;
      c = cell_index(it);
      if (it.op == OP_WRITE) begin
         diag_m[c]    = it.diag_coef;
         xpos_m[c]    = it.xpos_coef;
         ypos_m[c]    = it.ypos_coef;
         zpos_m[c]    = it.zpos_coef;
         vec_m[c]     = it.vec_value;
         fluid_m[c]   = it.is_fluid;
         written_m[c] = 1'b1;
         return 1'b0;
      end
      if (live_cell(it)) begin
         xp = cell_index(hood_cell(it, 1));
         yp = cell_index(hood_cell(it, 2));
         zp = cell_index(hood_cell(it, 3));
         xm = cell_index(hood_cell(it, 4));
         ym = cell_index(hood_cell(it, 5));
         zm = cell_index(hood_cell(it, 6));
         acc = mul_floor(diag_m[c], vec_m[c])
             + mul_floor(xpos_m[c], vec_m[xp])
             + mul_floor(ypos_m[c], vec_m[yp])
             + mul_floor(zpos_m[c], vec_m[zp])
             + mul_floor(xpos_m[xm], vec_m[xm])
             + mul_floor(ypos_m[ym], vec_m[ym])
             + mul_floor(zpos_m[zm], vec_m[zm]);
         if (acc > SAT_HI)
            acc = SAT_HI;
         else if (acc < SAT_LO)
            acc = SAT_LO;
         r.product = acc[OUT_W-1:0];
         r.active  = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic logic [FIELD_W-1:0] pick_value();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4, 5: return r;
         default: return {{12{r[19]}}, r[19:0]};
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      return ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6));
   endfunction

   function automatic req_type with_payload(input req_type it);
      req_type r;
      r = it;
      r.diag_coef = pick_value();
      r.xpos_coef = pick_value();
      r.ypos_coef = pick_value();
      r.zpos_coef = pick_value();
      r.vec_value = pick_value();
      r.is_fluid  = ($urandom_range(9) != 0);
      return r;
   endfunction

   function automatic stim_row_type mk_row(input logic op, input int x, input int y, input int z,
                                           input logic [31:0] d, input logic [31:0] cf,
                                           input logic [31:0] v, input logic fl,
                                           input bit typed, input logic [OUT_W-1:0] p,
                                           input logic a);
      stim_row_type row;
      row.item = '{op: op, cell_x: 4'(x), cell_y: 4'(y), cell_z: 4'(z), diag_coef: d,
                   xpos_coef: cf, ypos_coef: cf, zpos_coef: cf, vec_value: v, is_fluid: fl};
      row.typed = typed;
      row.want  = '{product: p, active: a};
      return row;
   endfunction

   // seven fluid cells around a centre, all with the same coefficients and vector value
   task automatic add_hood(input int x, input int y, input int z,
                           input logic [31:0] cf, input logic [31:0] v);
      stim_row_type row;
      row = mk_row(OP_WRITE, x, y, z, cf, cf, v, 1'b1, 1'b0, '0, 1'b0);
      for (int k = 0; k < 7; k++) begin
         stim_table.push_back('{item: hood_cell(row.item, k), typed: 1'b0, want: '0});
      end
   endtask

   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      rsp_type pred;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      if (predict_item(it, pred))
         pending_rsp.push_back(typed ? want : pred);
      req_data  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // computes only read cells written since reset: fill in the missing ones first
   task automatic random_step();
      req_type it;
      req_type nb;
      it.op     = ($urandom_range(99) < 45) ? OP_WRITE : OP_COMPUTE;
      it.cell_x = pick_coord();
      it.cell_y = pick_coord();
      it.cell_z = pick_coord();
      it = with_payload(it);
      if (it.op == OP_COMPUTE && live_cell(it)) begin
         for (int k = 0; k < 7; k++) begin
            nb = hood_cell(it, k);
            if (!written_m[cell_index(nb)]) begin
               nb.op = OP_WRITE;
               send_item(with_payload(nb), 1'b0, '0);
            end
         end
      end
      send_item(it, 1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_sizes(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                            input logic [SIZE_W-1:0] sz);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SIZE_X;
      csr_wdata    <= sx;
      @(posedge clock);
      csr_index    <= CSR_SIZE_Y;
      csr_wdata    <= sy;
      @(posedge clock);
      csr_index    <= CSR_SIZE_Z;
      csr_wdata    <= sz;
      @(posedge clock);
      csr_write_en <= 1'b0;
      size_x_q = sx;
      size_y_q = sy;
      size_z_q = sz;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
               $display("unexpected result: product %0d active %0b",
                        rsp_data.product, rsp_data.active);
         end else begin
            want_rsp = pending_rsp.pop_front();
            if (rsp_data.product !== want_rsp.product || rsp_data.active !== want_rsp.active) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("mismatch: product exp %0d got %0d, active exp %0b got %0b",
                           want_rsp.product, rsp_data.product, want_rsp.active,
                           rsp_data.active);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // no item moving on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT) begin
         $display("FAIL seven_point_stencil_matvec");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_SIZE_X;
      csr_wdata    = '0;

      // boundary cell, then an interior cell whose fluid flag is still clear
      stim_table.push_back(mk_row(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1, '0, 1'b0));
      stim_table.push_back(mk_row(OP_COMPUTE, 5, 5, 5, 0, 0, 0, 1'b0, 1'b1, '0, 1'b0));
      // all terms +2^46: positive saturation
      add_hood(1, 1, 1, 32'h8000_0000, 32'h8000_0000);
      stim_table.push_back(mk_row(OP_COMPUTE, 1, 1, 1, 0, 0, 0, 1'b0, 1'b1,
                                  48'h7FFF_FFFF_FFFF, 1'b1));
      // all terms near -2^46: negative saturation
      add_hood(5, 5, 5, 32'h8000_0000, 32'h7FFF_FFFF);
      stim_table.push_back(mk_row(OP_COMPUTE, 5, 5, 5, 0, 0, 0, 1'b0, 1'b1,
                                  48'h8000_0000_0000, 1'b1));
      stim_table.push_back(mk_row(OP_WRITE, 15, 15, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 1'b1, 1'b0, '0, 1'b0));
      stim_table.push_back(mk_row(OP_COMPUTE, 15, 15, 15, 0, 0, 0, 1'b0, 1'b1, '0, 1'b0));
      // solid interior cell
      stim_table.push_back(mk_row(OP_WRITE, 14, 14, 14, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 1'b0, 1'b0, '0, 1'b0));
      stim_table.push_back(mk_row(OP_COMPUTE, 14, 14, 14, 0, 0, 0, 1'b0, 1'b1, '0, 1'b0));
      // small values mixed with extremes, with negative terms through the floor shift
      stim_table.push_back(mk_row(OP_WRITE, 1, 1, 1, 32'hFFFF_FFFF, 32'h0000_0001,
                                  32'h0001_0000, 1'b1, 1'b0, '0, 1'b0));
      stim_table.push_back(mk_row(OP_COMPUTE, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, 1'b1, 1'b0, '0, 1'b0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         case (p / 2)
            0: begin
               req_idle_pct = 17;
               rsp_idle_pct <= 64;
            end
            1: begin
               req_idle_pct = 64;
               rsp_idle_pct <= 17;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
            end
         endcase
         if (p == 0) begin
            foreach (stim_table[i])
               send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
         end else begin
            set_sizes(phase_sx[p], phase_sy[p], phase_sz[p]);
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            random_step();
         drain();
      end

      if (bad_count == 0 && pending_rsp.size() == 0)
         $display("PASS seven_point_stencil_matvec");
      else
         $display("FAIL seven_point_stencil_matvec");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/sps_pkg.sv
hw/rtl/sps_ram.sv
hw/rtl/sps_mac.sv
hw/rtl/seven_point_stencil_matvec.sv
hw/rtl/sps_checker.sv
tb/testbench.sv
